// ===== rtl/core/pjq_pkg.sv =====
// pjq_pkg: shared types, constants and codes for the priority job queue
// no dependencies
`timescale 1ns / 1ps
package pjq_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned PRI_W  = 8;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned ST_W   = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_TAKE   = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_QUEUED = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_FULL       = 3'd3,
        ST_MISSING    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } state_t;

    // true if entry a runs before entry b
    function automatic logic runs_first(
        input logic [PRI_W-1:0]  pa,
        input logic [TIME_W-1:0] ta,
        input logic [ID_W-1:0]   ia,
        input logic [PRI_W-1:0]  pb,
        input logic [TIME_W-1:0] tb,
        input logic [ID_W-1:0]   ib
    );
        logic r;
        if (pa != pb)
        begin
            r = pa > pb;
        end
        else if (ta != tb)
        begin
            r = ta < tb;
        end
        else
        begin
            r = ia < ib;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pjq_store.sv =====
// pjq_store: slot memory for job entries, one read and one write port
// depends on pjq_pkg
`timescale 1ns / 1ps
module pjq_store #(
    parameter int unsigned CAPACITY = pjq_pkg::CAPACITY_DEF,
    parameter int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_idx,
    input  logic [pjq_pkg::ID_W-1:0]      wr_id,
    input  logic [pjq_pkg::PRI_W-1:0]     wr_pri,
    input  logic [pjq_pkg::TIME_W-1:0]    wr_time,
    input  logic [IDX_W-1:0]              rd_idx,
    output logic [pjq_pkg::ID_W-1:0]      rd_id,
    output logic [pjq_pkg::PRI_W-1:0]     rd_pri,
    output logic [pjq_pkg::TIME_W-1:0]    rd_time
);
    localparam int unsigned ENT_W = pjq_pkg::ID_W + pjq_pkg::PRI_W + pjq_pkg::TIME_W;

    logic [ENT_W-1:0] mem [CAPACITY];
    logic [ENT_W-1:0] rd_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr_id, wr_pri, wr_time};
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_idx];
    end

    assign rd_id   = rd_reg[ENT_W-1 -: pjq_pkg::ID_W];
    assign rd_pri  = rd_reg[pjq_pkg::TIME_W +: pjq_pkg::PRI_W];
    assign rd_time = rd_reg[pjq_pkg::TIME_W-1:0];
endmodule

// ===== rtl/core/priority_job_queue_unit.sv =====
// priority_job_queue_unit: top level, sequencer plus one shared compare unit
// depends on pjq_pkg and pjq_store
// an accepted item's first result follows a scan of every slot and the decide state, later under out_stall
// a list gives one result per entry, each after its own slot scan
// one item in work at a time; each scan reads the slots one by one through the single store read port
// reset: asynchronous active low, clears valid bits, count and sequencer state
`timescale 1ns / 1ps
module priority_job_queue_unit #(
    parameter int unsigned CAPACITY = pjq_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [pjq_pkg::ID_W-1:0]    job_id,
    input  logic [pjq_pkg::PRI_W-1:0]   job_priority,
    input  logic [pjq_pkg::TIME_W-1:0]  job_time,
    input  logic                        is_queued,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pjq_pkg::ST_W-1:0]    status,
    output logic [pjq_pkg::ID_W-1:0]    out_id,
    output logic [pjq_pkg::PRI_W-1:0]   out_priority,
    output logic [pjq_pkg::TIME_W-1:0]  out_time,
    output logic [$clog2(CAPACITY+1)-1:0] entry_count,
    output logic                        last
);
    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0] LAST_IDX = (IDX_W+1)'(CAPACITY - 1);

    pjq_pkg::state_t state_reg, state_next;

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CAPACITY-1:0] done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;

    pjq_pkg::op_t op_reg, op_next;
    logic [pjq_pkg::ID_W-1:0]   id_reg, id_next;
    logic [pjq_pkg::PRI_W-1:0]  pri_reg, pri_next;
    logic [pjq_pkg::TIME_W-1:0] time_reg, time_next;
    logic queued_reg, queued_next;

    // scan counters: address issued and address whose data is back
    logic [IDX_W:0] addr_reg, addr_next;
    logic [IDX_W-1:0] chk_reg, chk_next;
    logic chk_on_reg, chk_on_next;

    // best / match tracker
    logic found_reg, found_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;
    logic [pjq_pkg::ID_W-1:0]   fid_reg, fid_next;
    logic [pjq_pkg::PRI_W-1:0]  fpri_reg, fpri_next;
    logic [pjq_pkg::TIME_W-1:0] ftime_reg, ftime_next;

    // output register
    logic ov_reg, ov_next;
    logic [pjq_pkg::ST_W-1:0] st_reg, st_next;
    logic [pjq_pkg::ID_W-1:0]   oid_reg, oid_next;
    logic [pjq_pkg::PRI_W-1:0]  opri_reg, opri_next;
    logic [pjq_pkg::TIME_W-1:0] otime_reg, otime_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;
    logic olast_reg, olast_next;

    logic [pjq_pkg::ID_W-1:0]   rd_id;
    logic [pjq_pkg::PRI_W-1:0]  rd_pri;
    logic [pjq_pkg::TIME_W-1:0] rd_time;
    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic free_found;
    logic [IDX_W-1:0] free_idx;
    logic accept_in;
    logic out_free;
    logic slot_ok;
    logic better;

    pjq_store #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_id   (id_reg),
        .wr_pri  (pri_reg),
        .wr_time (time_reg),
        .rd_idx  (addr_reg[IDX_W-1:0]),
        .rd_id   (rd_id),
        .rd_pri  (rd_pri),
        .rd_time (rd_time)
    );

    assign accept_in = in_valid && !in_stall;
    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != pjq_pkg::S_IDLE);

    // lowest free slot, priority encoder over valid bits
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // shared compare unit on the slot just read
    always_comb
    begin
        slot_ok = chk_on_reg && valid_reg[chk_reg] && !done_reg[chk_reg];
        better = !found_reg || pjq_pkg::runs_first(rd_pri, rd_time, rd_id,
                                                   fpri_reg, ftime_reg, fid_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pjq_pkg::S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = pjq_pkg::S_SCAN;
                end
            end
            pjq_pkg::S_SCAN:
            begin
                if (!chk_on_reg && addr_reg > LAST_IDX)
                begin
                    state_next = pjq_pkg::S_DECIDE;
                end
            end
            pjq_pkg::S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = pjq_pkg::S_OUT;
                end
            end
            pjq_pkg::S_OUT:
            begin
                if (op_reg == pjq_pkg::OP_LIST && emitted_reg != count_reg)
                begin
                    state_next = pjq_pkg::S_SCAN;
                end
                else
                begin
                    state_next = pjq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pjq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        valid_next   = valid_reg;
        done_next    = done_reg;
        count_next   = count_reg;
        emitted_next = emitted_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        pri_next     = pri_reg;
        time_next    = time_reg;
        queued_next  = queued_reg;
        addr_next    = addr_reg;
        chk_next     = chk_reg;
        chk_on_next  = 1'b0;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        fid_next     = fid_reg;
        fpri_next    = fpri_reg;
        ftime_next   = ftime_reg;
        ov_next      = ov_reg && out_stall;
        st_next      = st_reg;
        oid_next     = oid_reg;
        opri_next    = opri_reg;
        otime_next   = otime_reg;
        ocnt_next    = ocnt_reg;
        olast_next   = olast_reg;
        wr_en        = 1'b0;
        wr_idx       = free_idx;
        unique case (state_reg)
            pjq_pkg::S_IDLE:
            begin
                if (accept_in)
                begin
                    op_next      = pjq_pkg::op_t'(operation);
                    id_next      = job_id;
                    pri_next     = job_priority;
                    time_next    = job_time;
                    queued_next  = is_queued;
                    done_next    = '0;
                    emitted_next = '0;
                    addr_next    = '0;
                    found_next   = 1'b0;
                end
            end
            pjq_pkg::S_SCAN:
            begin
                if (addr_reg <= LAST_IDX)
                begin
                    chk_on_next = 1'b1;
                    chk_next    = addr_reg[IDX_W-1:0];
                    addr_next   = addr_reg + 1'b1;
                end
                if (slot_ok)
                begin
                    if (op_reg == pjq_pkg::OP_POP || op_reg == pjq_pkg::OP_LIST)
                    begin
                        if (better)
                        begin
                            found_next = 1'b1;
                            fidx_next  = chk_reg;
                            fid_next   = rd_id;
                            fpri_next  = rd_pri;
                            ftime_next = rd_time;
                        end
                    end
                    else if (rd_id == id_reg && !found_reg)
                    begin
                        found_next = 1'b1;
                        fidx_next  = chk_reg;
                        fid_next   = rd_id;
                        fpri_next  = rd_pri;
                        ftime_next = rd_time;
                    end
                end
            end
            pjq_pkg::S_DECIDE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oid_next   = '0;
                    opri_next  = '0;
                    otime_next = '0;
                    olast_next = 1'b1;
                    st_next    = pjq_pkg::ST_OK;
                    ocnt_next  = count_reg;
                    unique case (op_reg)
                        pjq_pkg::OP_INSERT:
                        begin
                            if (!queued_reg)
                            begin
                                st_next = pjq_pkg::ST_NOT_QUEUED;
                            end
                            else if (found_reg)
                            begin
                                st_next = pjq_pkg::ST_DUPLICATE;
                            end
                            else if (!free_found)
                            begin
                                st_next = pjq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en                = 1'b1;
                                valid_next[free_idx] = 1'b1;
                                count_next           = count_reg + 1'b1;
                                ocnt_next            = count_reg + 1'b1;
                            end
                        end
                        pjq_pkg::OP_POP, pjq_pkg::OP_TAKE:
                        begin
                            if (!found_reg)
                            begin
                                st_next = pjq_pkg::ST_MISSING;
                            end
                            else
                            begin
                                valid_next[fidx_reg] = 1'b0;
                                count_next = count_reg - 1'b1;
                                ocnt_next  = count_reg - 1'b1;
                                oid_next   = fid_reg;
                                opri_next  = fpri_reg;
                                otime_next = ftime_reg;
                            end
                        end
                        pjq_pkg::OP_LIST:
                        begin
                            if (!found_reg)
                            begin
                                st_next = pjq_pkg::ST_MISSING;
                            end
                            else
                            begin
                                done_next[fidx_reg] = 1'b1;
                                emitted_next = emitted_reg + 1'b1;
                                olast_next = (emitted_reg + 1'b1) == count_reg;
                                oid_next   = fid_reg;
                                opri_next  = fpri_reg;
                                otime_next = ftime_reg;
                            end
                        end
                        default:
                        begin
                            st_next = pjq_pkg::ST_MISSING;
                        end
                    endcase
                end
            end
            pjq_pkg::S_OUT:
            begin
                addr_next  = '0;
                found_next = 1'b0;
                if (op_reg == pjq_pkg::OP_LIST && emitted_reg == '0)
                begin
                    emitted_next = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pjq_pkg::S_IDLE;
            valid_reg   <= '0;
            count_reg   <= '0;
            ov_reg      <= 1'b0;
            chk_on_reg  <= 1'b0;
            found_reg   <= 1'b0;
            done_reg    <= '0;
            emitted_reg <= '0;
            addr_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            ov_reg      <= ov_next;
            chk_on_reg  <= chk_on_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
            emitted_reg <= emitted_next;
            addr_reg    <= addr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        pri_reg    <= pri_next;
        time_reg   <= time_next;
        queued_reg <= queued_next;
        chk_reg    <= chk_next;
        fidx_reg   <= fidx_next;
        fid_reg    <= fid_next;
        fpri_reg   <= fpri_next;
        ftime_reg  <= ftime_next;
        st_reg     <= st_next;
        oid_reg    <= oid_next;
        opri_reg   <= opri_next;
        otime_reg  <= otime_next;
        ocnt_reg   <= ocnt_next;
        olast_reg  <= olast_next;
    end

    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign out_id       = oid_reg;
    assign out_priority = opri_reg;
    assign out_time     = otime_reg;
    assign entry_count  = ocnt_reg;
    assign last         = olast_reg;

`ifndef SYNTHESIS
    // count always matches the number of valid bits
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("entry count does not match valid slots");

    // no new item while a previous one is still in work
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != pjq_pkg::S_IDLE |-> in_stall)
        else $error("input taken while busy");

    // a result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ($stable(oid_reg) && $stable(st_reg)))
        else $error("stalled result overwritten");

    // a non-ok status carries no entry
    a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && st_reg != pjq_pkg::ST_OK) |-> (oid_reg == '0 && otime_reg == '0))
        else $error("error result carries entry data");
`endif
endmodule

// ===== sim/tb_priority_job_queue_unit.sv =====
// tb_priority_job_queue_unit: self-checking bench for the priority job queue
// depends on pjq_pkg and priority_job_queue_unit; predicts results in-bench
`timescale 1ns / 1ps
module tb_priority_job_queue_unit;

    localparam int CAP = pjq_pkg::CAPACITY_DEF;

    typedef struct packed {
        logic [1:0]                 op;
        logic [pjq_pkg::ID_W-1:0]   id;
        logic [pjq_pkg::PRI_W-1:0]  pri;
        logic [pjq_pkg::TIME_W-1:0] tim;
        logic                       queued;
    } job_req_t;

    typedef struct packed {
        logic [pjq_pkg::ST_W-1:0]   st;
        logic [pjq_pkg::ID_W-1:0]   id;
        logic [pjq_pkg::PRI_W-1:0]  pri;
        logic [pjq_pkg::TIME_W-1:0] tim;
        logic [4:0]                 cnt;
        logic                       lst;
    } job_resp_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] operation;
    logic [pjq_pkg::ID_W-1:0] job_id;
    logic [pjq_pkg::PRI_W-1:0] job_priority;
    logic [pjq_pkg::TIME_W-1:0] job_time;
    logic is_queued;
    logic out_valid;
    logic out_stall;
    logic [pjq_pkg::ST_W-1:0] status;
    logic [pjq_pkg::ID_W-1:0] out_id;
    logic [pjq_pkg::PRI_W-1:0] out_priority;
    logic [pjq_pkg::TIME_W-1:0] out_time;
    logic [4:0] entry_count;
    logic last;

    job_req_t  pending_jobs[$];
    job_resp_t expected_resp[$];
    int        error_count;

    // predictor state
    bit                         mdl_valid[CAP];
    logic [pjq_pkg::ID_W-1:0]   mdl_id[CAP];
    logic [pjq_pkg::PRI_W-1:0]  mdl_pri[CAP];
    logic [pjq_pkg::TIME_W-1:0] mdl_tim[CAP];
    int                         mdl_count;

    // known ids, used to aim takes and duplicates at stored entries
    logic [pjq_pkg::ID_W-1:0] used_ids[$];

    priority_job_queue_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .job_id(job_id), .job_priority(job_priority),
        .job_time(job_time), .is_queued(is_queued),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_id(out_id), .out_priority(out_priority),
        .out_time(out_time), .entry_count(entry_count), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit beats(int a, int b);
        if (mdl_pri[a] != mdl_pri[b])
            return mdl_pri[a] > mdl_pri[b];
        if (mdl_tim[a] != mdl_tim[b])
            return mdl_tim[a] < mdl_tim[b];
        return mdl_id[a] < mdl_id[b];
    endfunction

    function automatic job_resp_t mk_resp(pjq_pkg::status_t st, int slot, bit lst);
        job_resp_t r;
        r.st  = st;
        r.id  = (slot >= 0) ? mdl_id[slot] : '0;
        r.pri = (slot >= 0) ? mdl_pri[slot] : '0;
        r.tim = (slot >= 0) ? mdl_tim[slot] : '0;
        r.cnt = mdl_count[4:0];
        r.lst = lst;
        return r;
    endfunction

    function automatic int find_job(logic [pjq_pkg::ID_W-1:0] id);
        for (int i = 0; i < CAP; i++)
            if (mdl_valid[i] && mdl_id[i] == id)
                return i;
        return -1;
    endfunction

    // append one expected result
    task automatic add_expected(job_resp_t r);
        expected_resp = {expected_resp, r};
    endtask

    // append one item to the stimulus queue
    task automatic add_job(job_req_t j);
        pending_jobs = {pending_jobs, j};
    endtask

    // compute expected results of one accepted item
    task automatic predict_queue(job_req_t j);
        int s;
        int n;
        bit done[CAP];
        unique case (pjq_pkg::op_t'(j.op))
            pjq_pkg::OP_INSERT:
            begin
                s = -1;
                for (int i = CAP - 1; i >= 0; i--)
                    if (!mdl_valid[i])
                        s = i;
                if (!j.queued)
                    add_expected(mk_resp(pjq_pkg::ST_NOT_QUEUED, -1, 1'b1));
                else if (find_job(j.id) >= 0)
                    add_expected(mk_resp(pjq_pkg::ST_DUPLICATE, -1, 1'b1));
                else if (s < 0)
                    add_expected(mk_resp(pjq_pkg::ST_FULL, -1, 1'b1));
                else
                begin
                    mdl_valid[s] = 1'b1;
                    mdl_id[s] = j.id;
                    mdl_pri[s] = j.pri;
                    mdl_tim[s] = j.tim;
                    mdl_count++;
                    add_expected(mk_resp(pjq_pkg::ST_OK, -1, 1'b1));
                end
            end
            pjq_pkg::OP_POP, pjq_pkg::OP_TAKE:
            begin
                s = -1;
                if (pjq_pkg::op_t'(j.op) == pjq_pkg::OP_TAKE)
                    s = find_job(j.id);
                else
                    for (int i = 0; i < CAP; i++)
                        if (mdl_valid[i] && (s < 0 || beats(i, s)))
                            s = i;
                if (s < 0)
                    add_expected(mk_resp(pjq_pkg::ST_MISSING, -1, 1'b1));
                else
                begin
                    mdl_valid[s] = 1'b0;
                    mdl_count--;
                    add_expected(mk_resp(pjq_pkg::ST_OK, s, 1'b1));
                end
            end
            default:
            begin
                if (mdl_count == 0)
                    add_expected(mk_resp(pjq_pkg::ST_MISSING, -1, 1'b1));
                for (n = 0; n < mdl_count; n++)
                begin
                    s = -1;
                    for (int i = 0; i < CAP; i++)
                        if (mdl_valid[i] && !done[i] && (s < 0 || beats(i, s)))
                            s = i;
                    done[s] = 1'b1;
                    add_expected(mk_resp(pjq_pkg::ST_OK, s, n + 1 == mdl_count));
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic job_req_t mk_job(logic [1:0] op, logic [pjq_pkg::ID_W-1:0] id,
                                        logic [pjq_pkg::PRI_W-1:0] pri,
                                        logic [pjq_pkg::TIME_W-1:0] tim,
                                        logic q);
        job_req_t j;
        j.op = op; j.id = id; j.pri = pri; j.tim = tim; j.queued = q;
        return j;
    endfunction

    function automatic logic [pjq_pkg::ID_W-1:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return {$urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 40))};
    endfunction

    // driver: one item at a time, random gap before each
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            operation    <= pjq_pkg::OP_INSERT;
            job_id       <= '0;
            job_priority <= '0;
            job_time     <= '0;
            is_queued    <= 1'b0;
            in_gap = 0;
        end
        else if (in_valid && !in_stall)
        begin
            predict_queue(pending_jobs.pop_front());
            in_gap = $urandom_range(0, 5);
            if (in_gap == 0 && pending_jobs.size() > 0)
            begin
                operation    <= pending_jobs[0].op;
                job_id       <= pending_jobs[0].id;
                job_priority <= pending_jobs[0].pri;
                job_time     <= pending_jobs[0].tim;
                is_queued    <= pending_jobs[0].queued;
            end
            else
                in_valid <= 1'b0;
        end
        else if (!in_valid)
        begin
            if (in_gap > 0)
                in_gap--;
            else if (pending_jobs.size() > 0)
            begin
                in_valid     <= 1'b1;
                operation    <= pending_jobs[0].op;
                job_id       <= pending_jobs[0].id;
                job_priority <= pending_jobs[0].pri;
                job_time     <= pending_jobs[0].tim;
                is_queued    <= pending_jobs[0].queued;
            end
        end
    end

    // monitor: check each accepted result, then draw the next stall
    int out_hold;
    always @(posedge clk or negedge rst_n)
    begin
        job_resp_t w;
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            out_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_resp.size() == 0)
                    report_mismatch("unexpected result", {61'b0, status}, 64'b0);
                else
                begin
                    w = expected_resp.pop_front();
                    if (status != w.st) report_mismatch("status", status, w.st);
                    if (out_id != w.id) report_mismatch("out_id", out_id, w.id);
                    if (out_priority != w.pri)
                        report_mismatch("out_priority", out_priority, w.pri);
                    if (out_time != w.tim) report_mismatch("out_time", out_time, w.tim);
                    if (entry_count != w.cnt)
                        report_mismatch("entry_count", entry_count, w.cnt);
                    if (last != w.lst) report_mismatch("last", last, w.lst);
                end
                out_hold = $urandom_range(0, 5);
                out_stall <= (out_hold != 0);
            end
            else if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= (out_hold != 0);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // stimulus
    initial
    begin
        job_req_t j;
        int kind;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, extremes, ties, not queued, duplicate, full
        add_job(mk_job(pjq_pkg::OP_POP, '0, '0, '0, 1'b1));
        add_job(mk_job(pjq_pkg::OP_LIST, '0, '0, '0, 1'b1));
        add_job(mk_job(pjq_pkg::OP_TAKE, '1, '0, '0, 1'b1));
        add_job(mk_job(pjq_pkg::OP_INSERT, 32'd5, 8'd9, 48'd7, 1'b0));
        add_job(mk_job(pjq_pkg::OP_INSERT, '1, '1, '1, 1'b1));
        add_job(mk_job(pjq_pkg::OP_INSERT, '0, '0, '0, 1'b1));
        add_job(mk_job(pjq_pkg::OP_INSERT, '1, 8'd3, 48'd3, 1'b1));
        add_job(mk_job(pjq_pkg::OP_INSERT, 32'd7, 8'd50, 48'd100, 1'b1));
        add_job(mk_job(pjq_pkg::OP_INSERT, 32'd6, 8'd50, 48'd100, 1'b1));
        add_job(mk_job(pjq_pkg::OP_INSERT, 32'd8, 8'd50, 48'd99, 1'b1));
        add_job(mk_job(pjq_pkg::OP_LIST, '0, '0, '0, 1'b0));
        for (int i = 0; i < 12; i++)
            add_job(mk_job(pjq_pkg::OP_INSERT, 32'd100 + i, 8'(i), 48'(i), 1'b1));
        add_job(mk_job(pjq_pkg::OP_LIST, '0, '0, '0, 1'b1));
        add_job(mk_job(pjq_pkg::OP_TAKE, 32'd7, '0, '0, 1'b1));
        for (int i = 0; i < 17; i++)
            add_job(mk_job(pjq_pkg::OP_POP, '1, '1, '1, 1'b0));
        used_ids = '{32'd5, 32'd6, 32'd7, 32'd8};

        // random: bias toward inserts with small ids so ties and duplicates occur
        for (int n = 0; n < 268; n++)
        begin
            kind = $urandom_range(0, 9);
            j.op = (kind < 5) ? pjq_pkg::OP_INSERT : (kind < 7) ? pjq_pkg::OP_POP
                 : (kind < 9) ? pjq_pkg::OP_TAKE : pjq_pkg::OP_LIST;
            j.id = pick_id();
            j.pri = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom());
            j.tim = ($urandom_range(0, 1) != 0) ? 48'($urandom_range(0, 3))
                  : {16'($urandom()), 32'($urandom())};
            j.queued = ($urandom_range(0, 7) != 0);
            if (j.op == pjq_pkg::OP_INSERT)
                used_ids = {used_ids, j.id};
            add_job(j);
        end

        wait (pending_jobs.size() == 0 && !in_valid);
        wait (expected_resp.size() == 0);
        repeat (CAP * 8) @(posedge clk);
        if (error_count == 0 && expected_resp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/pjq_pkg.sv
rtl/core/pjq_store.sv
rtl/core/priority_job_queue_unit.sv
sim/tb_priority_job_queue_unit.sv
